// ----- design/wpp_pkg.sv -----
// Shared constants, widths and control structs for the window peak-to-peak detector.
package wpp_pkg;

    // History store geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int ADDR_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Field widths
    localparam int SAMPLE_W = 13;
    localparam int WL_W     = 6;
    localparam int THR_W    = 13;
    localparam int SPREAD_W = 13;

    // Scan length counter holds both window_length+1 and the store depth
    localparam int LEN_W = (CNT_W > WL_W + 1) ? CNT_W : WL_W + 1;

    // Register reset values
    localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(30);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2000);

    // Configuration register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_THRESHOLD     = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;    // take the input word, write it, arm the scan
        logic issue;     // read one history entry
        logic fold;      // fold the entry read last cycle into max/min
        logic load_out;  // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic evaluated;   // window is full enough for the word being accepted
        logic last_issue;  // the read issued now is the last of the window
    } t_sts;

endpackage

// ----- design/wpp_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module wpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/wpp_ctrl.sv -----
// Controller state machine: input handshake, scan sequencing and output handshake.
module wpp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  wpp_pkg::t_sts i_sts,
    output wpp_pkg::t_cmd o_cmd
);
    import wpp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   r_fold;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // Output register can take a new word when empty or being emptied now
    assign slot_free = !r_out_valid || !i_out_stall;

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.issue    = (r_state == ST_SCAN);
        o_cmd.fold     = r_fold;
        o_cmd.load_out = (r_state == ST_HOLD) && slot_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = i_sts.evaluated ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fold      <= o_cmd.issue;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/wpp_dp.sv -----
// Datapath: history pointers, scan address walk, running max/min and result register.
module wpp_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wpp_pkg::t_cmd                          i_cmd,
    output wpp_pkg::t_sts                          o_sts,
    input  logic signed [wpp_pkg::SAMPLE_W-1:0]    i_sample_y,
    input  logic [wpp_pkg::WL_W-1:0]               i_window_length,
    input  logic [wpp_pkg::THR_W-1:0]              i_threshold,
    output logic                                   o_evaluated,
    output logic [wpp_pkg::SPREAD_W-1:0]           o_spread,
    output logic                                   o_trigger
);
    import wpp_pkg::*;

    logic [ADDR_W-1:0]          r_wp;
    logic [CNT_W-1:0]           r_fill;
    logic [CNT_W-1:0]           n_fill;
    logic [ADDR_W-1:0]          r_rd_addr;
    logic [LEN_W-1:0]           r_remain;
    logic [LEN_W-1:0]           win_len;
    logic [LEN_W-1:0]           win_raw;
    logic                       r_eval;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic [SAMPLE_W-1:0]        rd_data;
    logic [SAMPLE_W:0]          diff;
    logic [SPREAD_W-1:0]        spread;
    logic                       r_evaluated;
    logic [SPREAD_W-1:0]        r_spread;
    logic                       r_trigger;

    // History store
    wpp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wp),
        .i_wdata (i_sample_y),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    // Window length, capped at the store depth
    assign win_raw = LEN_W'(i_window_length) + LEN_W'(1);
    assign win_len = (win_raw > LEN_W'(HISTORY_DEPTH)) ? LEN_W'(HISTORY_DEPTH) : win_raw;

    // Fill count saturates at the store depth
    assign n_fill = (r_fill == CNT_W'(HISTORY_DEPTH)) ? r_fill : r_fill + CNT_W'(1);

    assign o_sts.evaluated  = (LEN_W'(n_fill) >= win_len);
    assign o_sts.last_issue = (r_remain == LEN_W'(1));

    // Write pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_wp   <= (r_wp == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
            r_fill <= n_fill;
        end
    end

    // Scan walk: newest entry first, backwards with wrap
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_addr <= r_wp;
            r_remain  <= win_len;
            r_eval    <= o_sts.evaluated;
        end else if (i_cmd.issue) begin
            r_rd_addr <= (r_rd_addr == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                           : r_rd_addr - ADDR_W'(1);
            r_remain  <= r_remain - LEN_W'(1);
        end
    end

    // Running max and min, both start at zero
    assign rd_sample = rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.fold) begin
            if (rd_sample > r_hi) begin
                r_hi <= rd_sample;
            end
            if (rd_sample < r_lo) begin
                r_lo <= rd_sample;
            end
        end
    end

    // Spread of the running max and min
    assign diff   = {r_hi[SAMPLE_W-1], r_hi} - {r_lo[SAMPLE_W-1], r_lo};
    assign spread = diff[SPREAD_W-1:0];

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_evaluated <= r_eval;
            r_spread    <= spread;
            r_trigger   <= r_eval && (spread > i_threshold);
        end
    end

    assign o_evaluated = r_evaluated;
    assign o_spread    = r_spread;
    assign o_trigger   = r_trigger;

endmodule

// ----- design/window_peak_to_peak_detector.sv -----
// Top level: configuration registers, controller and datapath of the peak-to-peak detector.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_sample_y
//   out      source     o_out_valid / i_out_stall  o_evaluated, o_spread, o_trigger
//   cfg      APB        psel / penable / pready    paddr, pwdata, prdata
//
// After accept, a word scans n history entries, n = min(window_length+1, depth), then
// passes a flush state and loads its result once the output register is free; the next
// word is taken after the load. The single read port of the history RAM sets the scan to
// one entry per cycle. Words whose window is not yet filled skip the scan and go to the load.
// Reset is synchronous; the RAM needs no clearing since only filled entries are read.
// A finished result waits in the output register while the next word is accepted.
module window_peak_to_peak_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [wpp_pkg::SAMPLE_W-1:0] i_sample_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_evaluated,
    output logic [wpp_pkg::SPREAD_W-1:0]        o_spread,
    output logic                                o_trigger,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpp_pkg::PADDR_W-1:0]         paddr,
    input  logic [wpp_pkg::PDATA_W-1:0]         pwdata,
    output logic [wpp_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import wpp_pkg::*;

    logic [WL_W-1:0]  r_window_length;
    logic [THR_W-1:0] r_threshold;
    logic             reg_wr;
    logic             reg_sel;
    t_cmd             cmd;
    t_sts             sts;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
            r_threshold     <= THR_RESET;
        end else if (reg_wr) begin
            unique case (reg_sel)
                REG_WINDOW_LENGTH: r_window_length <= pwdata[WL_W-1:0];
                REG_THRESHOLD:     r_threshold     <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (reg_sel)
            REG_WINDOW_LENGTH: prdata = PDATA_W'(r_window_length);
            REG_THRESHOLD:     prdata = PDATA_W'(r_threshold);
            default:           prdata = '0;
        endcase
    end

    wpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wpp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample_y      (i_sample_y),
        .i_window_length (r_window_length),
        .i_threshold     (r_threshold),
        .o_evaluated     (o_evaluated),
        .o_spread        (o_spread),
        .o_trigger       (o_trigger)
    );

endmodule

// ----- tb/window_peak_to_peak_detector_test.sv -----
// Self-checking testbench for the window peak-to-peak detector: directed and random samples.
module window_peak_to_peak_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wpp_pkg::*;

    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 120;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 80;

    typedef struct packed {
        logic                evaluated;
        logic [SPREAD_W-1:0] spread;
        logic                trigger;
    } t_spread_result;

    // Track the sample history and predict the window spread of every accepted word
    class t_spread_tracker;
        logic signed [SAMPLE_W-1:0] history [HISTORY_DEPTH];
        logic [ADDR_W-1:0]          wr_ptr;
        logic [CNT_W-1:0]           fill;
        logic [WL_W-1:0]            win_len;
        logic [THR_W-1:0]           thresh;
        t_spread_result             expected_results [$];
        int                         errors;

        function new();
            foreach (history[k]) history[k] = '0;
            wr_ptr  = '0;
            fill    = '0;
            win_len = WL_RESET;
            thresh  = THR_RESET;
            errors  = 0;
        endfunction

        function void set_reg(logic idx, logic [PDATA_W-1:0] value);
            if (idx == REG_WINDOW_LENGTH) begin
                win_len = value[WL_W-1:0];
            end else if (idx == REG_THRESHOLD) begin
                thresh = value[THR_W-1:0];
            end
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            int             span;
            int             hi;
            int             lo;
            logic [ADDR_W-1:0] rd;
            t_spread_result r;
            history[wr_ptr] = s;
            if (fill < HISTORY_DEPTH) fill++;
            span = int'(win_len) + 1;
            if (span > HISTORY_DEPTH) span = HISTORY_DEPTH;
            r  = '0;
            hi = 0;
            lo = 0;
            // Scan back from the newest entry once the window is filled
            if (int'(fill) >= span) begin
                r.evaluated = 1'b1;
                for (int k = 0; k < span; k++) begin
                    rd = wr_ptr - ADDR_W'(k);
                    if (history[rd] > hi) hi = history[rd];
                    if (history[rd] < lo) lo = history[rd];
                end
                r.spread  = SPREAD_W'(hi - lo);
                r.trigger = (r.spread > thresh);
            end
            wr_ptr++;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic ev, logic [SPREAD_W-1:0] sp, logic tr);
            t_spread_result e;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, evaluated %0b spread %0d trigger %0b",
                         $time, ev, sp, tr);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (ev !== e.evaluated) begin
                $display("%0t: evaluated mismatch, expected %0b, got %0b",
                         $time, e.evaluated, ev);
                errors++;
            end
            if (sp !== e.spread) begin
                $display("%0t: spread mismatch, expected %0d, got %0d", $time, e.spread, sp);
                errors++;
            end
            if (tr !== e.trigger) begin
                $display("%0t: trigger mismatch, expected %0b, got %0b", $time, e.trigger, tr);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample_y;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic                       o_evaluated;
    logic [SPREAD_W-1:0]        o_spread;
    logic                       o_trigger;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    t_spread_tracker tracker = new();
    bit              quiet_tail = 1'b0;
    bit              hold_out   = 1'b0;

    window_peak_to_peak_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_y  (i_sample_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_evaluated (o_evaluated),
        .o_spread    (o_spread),
        .o_trigger   (o_trigger),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Note accepted samples and check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && !o_in_stall) tracker.note_sample(i_sample_y);
            if (o_out_valid && !i_out_stall)
                tracker.check_result(o_evaluated, o_spread, o_trigger);
        end
    end

    // Stall the result side in short random bursts, or once for a long stretch
    initial begin : result_stall
        int k;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_out = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // End the run when no word moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        // Drop valid for a random gap before some words
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_y <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int amp);
        int v;
        // Cover the whole 13-bit span now and then, else stay within the amplitude
        if ($urandom_range(0, 9) == 0) return SAMPLE_W'($urandom);
        v = int'($urandom_range(0, 2 * amp)) - amp;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_burst(input int count);
        int amp;
        amp = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 20 == 0) amp = $urandom_range(0, 4095);
            send_sample(pick_sample(amp));
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic signed [SAMPLE_W-1:0] unfilled [];
        logic signed [SAMPLE_W-1:0] single   [];
        int unsigned wl_pick;
        int unsigned thr_pick;

        unfilled = '{SAMPLE_W'(-4096), SAMPLE_W'(4095), SAMPLE_W'(-4000),
                     SAMPLE_W'(4000), SAMPLE_W'(0)};
        single   = '{SAMPLE_W'(-4096), SAMPLE_W'(4095), SAMPLE_W'(0), SAMPLE_W'(-1),
                     SAMPLE_W'(1), SAMPLE_W'(4000), SAMPLE_W'(-4000)};

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_sample_y = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window not yet filled under the reset settings
        foreach (unfilled[k]) send_sample(unfilled[k]);
        drain();

        // Window of the newest sample only, zero threshold
        write_reg(REG_WINDOW_LENGTH, 0);
        write_reg(REG_THRESHOLD, 0);
        foreach (single[k]) send_sample(single[k]);
        drain();

        // Full-scale spread just above and at the threshold
        write_reg(REG_WINDOW_LENGTH, 3);
        write_reg(REG_THRESHOLD, 8190);
        send_sample(SAMPLE_W'(4095));
        send_sample(SAMPLE_W'(-4096));
        drain();
        write_reg(REG_THRESHOLD, 8191);
        send_sample(SAMPLE_W'(4095));
        send_sample(SAMPLE_W'(-4096));
        drain();

        // Random phases; the first one fills the whole store under the longest window
        for (int ph = 0; ph < PHASES; ph++) begin
            wl_pick  = (ph == 0 || ph == 3) ? 63 : (ph == 1) ? 0 : (ph == 2) ? 1
                       : $urandom_range(0, 63);
            thr_pick = (ph == 2) ? 0 : (ph == 3) ? 8191 : (ph == 5) ? $urandom_range(0, 8191)
                       : $urandom_range(0, 8000);
            write_reg(REG_WINDOW_LENGTH, wl_pick);
            write_reg(REG_THRESHOLD, thr_pick);
            if (ph == PHASES - 1) quiet_tail = 1'b1;
            if (ph == 4) hold_out = 1'b1;
            send_burst(PHASE_WORDS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (tracker.pending() != 0)
                $display("%0t: %0d expected results never arrived", $time, tracker.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
